>>> rtl/pci_host_bridge_config_space_defines.svh
// Assertion macros shared by the bridge RTL.
// Each macro places one labeled concurrent assertion, clocked on the rising edge
// and disabled while the asynchronous reset is asserted.
`ifndef PCI_HOST_BRIDGE_CONFIG_SPACE_DEFINES_SVH
`define PCI_HOST_BRIDGE_CONFIG_SPACE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication.
`define PHBCS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication check failed");
// Next-cycle implication.
`define PHBCS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");
`else
`define PHBCS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PHBCS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/phbcs_pkg.sv
`default_nettype none

package phbcs_pkg;

	// Request codes.
	localparam logic [1:0] REQ_PORT_READ  = 2'd0;
	localparam logic [1:0] REQ_PORT_WRITE = 2'd1;
	localparam logic [1:0] REQ_SEG_QUERY  = 2'd2;

	// Port offset of the address port relative to the base port.
	localparam logic [2:0] PORT_ADDRESS = 3'd0;
	localparam logic [2:0] PORT_DATA0   = 3'd4;

	localparam logic [2:0] LEN_DWORD = 3'd4;

	localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;
	localparam logic [31:0] CA_MATCH_MASK  = 32'h80FF_0000;
	localparam logic [31:0] CA_MATCH_VALUE = 32'h8000_0000;

	// Special offsets in the configuration space.
	localparam logic [7:0] OFF_COMMAND   = 8'h04;
	localparam logic [7:0] OFF_STATUS_LO = 8'h06;
	localparam logic [7:0] OFF_CACHE_LS  = 8'h0C;
	localparam logic [7:0] OFF_PAM0      = 8'h59;
	localparam logic [7:0] OFF_PAM1      = 8'h5A;
	localparam logic [7:0] OFF_BAR_FIRST = 8'h10;
	localparam logic [7:0] OFF_BAR_END   = 8'h34;

	localparam logic [7:0] CMD_KEEP_MASK = 8'h40;
	localparam logic [7:0] CMD_FORCED    = 8'h06;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_RISSUE,
		S_RWAIT,
		S_WRITE,
		S_DONE
	} phbcs_state_t;

	// Power-on contents of the configuration space.
	function automatic logic [7:0] cfg_reset_byte(input logic [7:0] off);
		logic [7:0] b;
		unique case (off)
			8'h00:   b = 8'h86;
			8'h01:   b = 8'h80;
			8'h02:   b = 8'h37;
			8'h03:   b = 8'h12;
			8'h04:   b = 8'h06;
			8'h06:   b = 8'h80;
			8'h07:   b = 8'h02;
			8'h0B:   b = 8'h06;
			8'h51:   b = 8'h01;
			8'h53:   b = 8'h80;
			8'h57:   b = 8'h01;
			8'h58:   b = 8'h10;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

>>> rtl/phbcs_ram.sv
`default_nettype none

module phbcs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/pci_host_bridge_config_space.sv
// Items are worked one at a time; the next item is taken the cycle after the result is
// registered. The configuration RAM is accessed one byte at a time.
// Reset clears the address register and the 256 per-byte valid bits at once, so the
// configuration space reads its power-on values immediately; there is no clearing pass.
`default_nettype none

`include "pci_host_bridge_config_space_defines.svh"

module pci_host_bridge_config_space (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [2:0]  port_offset,
	input  wire logic [2:0]  access_len,
	input  wire logic [31:0] wdata,
	input  wire logic [19:0] mem_addr,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      rdata,
	output logic             error,
	output logic             seg_read_dram,
	output logic             seg_write_dram
);

	import phbcs_pkg::*;

	// Sequencer state.
	phbcs_state_t state_q, state_d;

	// The request being worked on, captured at the input transfer.
	logic [1:0]  req_q;
	logic [2:0]  port_q;
	logic [2:0]  len_q;
	logic [31:0] wdata_q;
	logic [19:0] addr_q;

	// Architectural address register (the value written at the address port).
	logic [31:0] config_address_q;

	// Byte walk: base register number and byte counter. The counter only needs to
	// reach 3; after the last byte of a four-byte access it wraps, which is harmless.
	logic [7:0] reg_q;
	logic [1:0] cnt_q;
	logic       nib_q;

	// Result being assembled and the output register that holds a finished result
	// until the downstream side takes the transfer.
	logic [31:0] res_rdata_q;
	logic        res_err_q, res_rd_q, res_wr_q;
	logic        out_valid_q;
	logic [31:0] out_rdata_q;
	logic        out_err_q, out_rd_q, out_wr_q;

	// Configuration space storage: a 256-byte RAM plus one valid bit per byte. A byte
	// that has never been written reads back its power-on value from the package.
	logic [255:0] valid_q;
	logic         ram_we, ram_re;
	logic [7:0]   ram_waddr, ram_raddr, ram_wdata, ram_rdata;
	logic         rd_vld_s1;
	logic [7:0]   rd_init_s1;

	phbcs_ram #(
		.WIDTH(8),
		.DEPTH(256)
	) u_cfg_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// ------------------------------------------------------------------
	// Decode of the captured request. This is evaluated in the dispatch cycle.
	// ------------------------------------------------------------------
	logic       is_port, is_read, bridge_hit, len_ok, data_go, wr_pass, seg_hit, last_byte;
	logic [7:0] data_reg, byte_addr, wr_byte, rd_byte;
	logic [2:0] cnt_ext;

	assign is_port    = (req_q == REQ_PORT_READ) || (req_q == REQ_PORT_WRITE);
	assign is_read    = (req_q == REQ_PORT_READ);
	// The bridge answers only when enabled, on bus 0, at device 0 function 0.
	assign bridge_hit = ((config_address_q & CA_MATCH_MASK) == CA_MATCH_VALUE)
	                    && (config_address_q[15:8] == 8'h00);
	assign len_ok     = (len_q != 3'd0) && (len_q <= LEN_DWORD);
	assign data_go    = is_port && (port_q >= PORT_DATA0) && len_ok && bridge_hit;
	// Register number: dword-aligned address plus the byte lane of the data port.
	assign data_reg   = {config_address_q[7:2], 2'b00} + {6'b0, port_q[1:0]};
	// Write filter on the starting register: identity, revision, class code and header type
	// bytes and the BAR window reject the entire transfer.
	assign wr_pass    = (((data_reg >= 8'h04) && (data_reg <= 8'h07)) || (data_reg == 8'h0C)
	                    || (data_reg == 8'h0D) || (data_reg > 8'h0E))
	                    && !((data_reg >= OFF_BAR_FIRST) && (data_reg < OFF_BAR_END));
	// Segments C0000 and up are covered by the attribute bytes.
	assign seg_hit    = (addr_q[19:18] == 2'b11);

	// Shared byte address adder used by both the read and the write walk.
	assign byte_addr  = reg_q + {6'b0, cnt_q};
	assign cnt_ext    = {1'b0, cnt_q};
	assign last_byte  = ((cnt_ext + 3'd1) == len_q);

	// Data byte returned by the RAM, with never-written bytes showing their reset value.
	assign rd_byte    = rd_vld_s1 ? ram_rdata : rd_init_s1;

	// Current write lane; the command register keeps only one writable bit.
	always_comb begin
		wr_byte = wdata_q[{cnt_q, 3'b000} +: 8];
		if (byte_addr == OFF_COMMAND) begin
			wr_byte = (wr_byte & CMD_KEEP_MASK) | CMD_FORCED;
		end
	end

	// ------------------------------------------------------------------
	// Next state.
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (req_q == REQ_SEG_QUERY && seg_hit) begin
					state_d = S_RISSUE;
				end else if (data_go && is_read) begin
					state_d = S_RISSUE;
				end else if (data_go && wr_pass) begin
					state_d = S_WRITE;
				end else begin
					state_d = S_DONE;
				end
			end
			S_RISSUE: state_d = S_RWAIT;
			S_RWAIT: begin
				if (req_q == REQ_SEG_QUERY || last_byte) begin
					state_d = S_DONE;
				end else begin
					state_d = S_RISSUE;
				end
			end
			S_WRITE: begin
				if (last_byte) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer outputs: handshake and RAM controls.
	// ------------------------------------------------------------------
	always_comb begin
		in_ready  = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = byte_addr;
		ram_we    = 1'b0;
		ram_waddr = byte_addr;
		ram_wdata = wr_byte;
		unique case (state_q)
			S_IDLE:   in_ready = 1'b1;
			S_RISSUE: ram_re = 1'b1;
			// Status low byte and the cache line size byte are silently skipped.
			S_WRITE:  ram_we = (byte_addr != OFF_STATUS_LO) && (byte_addr != OFF_CACHE_LS);
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Valid bits for the configuration bytes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ram_we) begin
			valid_q[ram_waddr] <= 1'b1;
		end
	end

	// Valid bit and power-on value travel alongside the registered RAM read.
	always_ff @(posedge clk) begin
		if (ram_re) begin
			rd_vld_s1  <= valid_q[ram_raddr];
			rd_init_s1 <= cfg_reset_byte(ram_raddr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			config_address_q <= '0;
		end else if (state_q == S_DISPATCH && is_port && port_q == PORT_ADDRESS
		             && len_q == LEN_DWORD && !is_read) begin
			config_address_q <= wdata_q;
		end
	end

	// ------------------------------------------------------------------
	// Datapath registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					req_q   <= req_type;
					port_q  <= port_offset;
					len_q   <= access_len;
					wdata_q <= wdata;
					addr_q  <= mem_addr;
				end
			end
			S_DISPATCH: begin
				cnt_q       <= 2'd0;
				res_err_q   <= 1'b0;
				res_rd_q    <= 1'b0;
				res_wr_q    <= 1'b0;
				res_rdata_q <= is_read ? ALL_ONES : 32'h0;
				nib_q       <= 1'b0;
				reg_q       <= data_reg;
				if (is_port) begin
					if (port_q == PORT_ADDRESS) begin
						if (len_q != LEN_DWORD) begin
							res_err_q <= 1'b1;
						end else if (is_read) begin
							res_rdata_q <= config_address_q;
						end
					end else if (port_q < PORT_DATA0) begin
						res_err_q <= 1'b1;
					end else if (data_go && is_read) begin
						// Bytes beyond the access length read as zero.
						res_rdata_q <= 32'h0;
					end
				end else if (req_q == REQ_SEG_QUERY) begin
					if (!seg_hit) begin
						res_err_q <= 1'b1;
					end else if (addr_q[19:16] == 4'hF) begin
						// The upper BIOS segment is governed by the high nibble.
						reg_q <= OFF_PAM0;
						nib_q <= 1'b1;
					end else begin
						// Two 16 KiB segments per attribute byte, low one in the low nibble.
						reg_q <= OFF_PAM1 + {5'b0, addr_q[17:15]};
						nib_q <= addr_q[14];
					end
				end else begin
					res_rdata_q <= ALL_ONES;
					res_err_q   <= 1'b1;
				end
			end
			S_RWAIT: begin
				if (req_q == REQ_SEG_QUERY) begin
					res_rd_q <= rd_byte[{nib_q, 2'b00}];
					res_wr_q <= rd_byte[{nib_q, 2'b01}];
				end else begin
					res_rdata_q[{cnt_q, 3'b000} +: 8] <= rd_byte;
					cnt_q <= cnt_q + 2'd1;
				end
			end
			S_WRITE: cnt_q <= cnt_q + 2'd1;
			default: begin
			end
		endcase
	end

	// Output register: filled in the done state once the previous result has left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			out_rdata_q <= res_rdata_q;
			out_err_q   <= res_err_q;
			out_rd_q    <= res_rd_q;
			out_wr_q    <= res_wr_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign rdata          = out_rdata_q;
	assign error          = out_err_q;
	assign seg_read_dram  = out_rd_q;
	assign seg_write_dram = out_wr_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	`PHBCS_ASSERT_NXT(a_busy_after_take, clk, arst_n, in_valid && in_ready, !in_ready)
	`PHBCS_ASSERT_IMP(a_no_ro_write, clk, arst_n, ram_we, ram_waddr != OFF_STATUS_LO && ram_waddr != OFF_CACHE_LS)
	`PHBCS_ASSERT_IMP(a_cmd_forced, clk, arst_n, ram_we && ram_waddr == OFF_COMMAND, (ram_wdata & ~(CMD_KEEP_MASK | CMD_FORCED)) == 8'h00 && (ram_wdata & CMD_FORCED) == CMD_FORCED)
	`PHBCS_ASSERT_IMP(a_walk_in_len, clk, arst_n, (state_q == S_RWAIT || state_q == S_WRITE) && req_q != REQ_SEG_QUERY, cnt_ext < len_q)

endmodule

`default_nettype wire

>>> bench/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import phbcs_pkg::*;

	// The request code that the bridge does not define; it must be rejected.
	localparam logic [1:0] REQ_UNDEFINED = 2'd3;

	// Port offsets between the address port and the data port are not decoded.
	localparam logic [2:0] PORT_GAP_LO = 3'd1;
	localparam logic [2:0] PORT_GAP_HI = 3'd3;

	// Header registers that bound the write filter of the bridge.
	localparam logic [7:0] CMD_STATUS_LAST = 8'h07;
	localparam logic [7:0] LATENCY_TIMER   = 8'h0D;
	localparam logic [7:0] HEADER_TYPE     = 8'h0E;

	// Legacy memory segments, in units of 4 KiB: C0000 starts the option ROM area,
	// and F0000 is the system BIOS segment with its own attribute byte.
	localparam logic [7:0] SEG_FIRST_LEGACY = 8'hC0;
	localparam logic [7:0] SEG_UPPER_BIOS   = 8'hF0;

	localparam int TARGET_ITEMS    = 1150;
	localparam int CALM_FIRST      = 450;
	localparam int CALM_LAST       = 650;
	localparam int SQUEEZE_AT      = 800;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int QUIET_LIMIT     = 3000;
	localparam int DRAIN_CYCLES    = 20;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  port;
		logic [2:0]  len;
		logic [31:0] wdata;
		logic [19:0] mem_addr;
	} bridge_req_t;

	typedef struct packed {
		logic [31:0] rdata;
		logic        err;
		logic        rd_dram;
		logic        wr_dram;
	} bridge_rsp_t;

	// One line of the directed script. When fixed is set, the response was worked out
	// by hand and is checked as written; otherwise the predictor supplies it.
	typedef struct {
		bridge_req_t req;
		bit          fixed;
		bridge_rsp_t rsp;
	} script_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  req_type;
	logic [2:0]  port_offset;
	logic [2:0]  access_len;
	logic [31:0] wdata;
	logic [19:0] mem_addr;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] rdata;
	logic        error;
	logic        seg_read_dram;
	logic        seg_write_dram;

	// Shadow copy of the bridge state, advanced once per accepted transfer.
	logic [31:0] cfg_addr_model;
	logic [7:0]  cfg_space_model [0:255];

	bridge_rsp_t awaited_responses [$];
	script_row_t directed_rows [$];

	// Traffic shaping shared between the sender and the receiver.
	bit calm;
	bit sink_hold_req;

	int items_sent;
	int results_checked;
	int bad_results;
	int quiet_cycles;
	int n_port_reads;
	int n_port_writes;
	int n_seg_queries;
	int n_undefined;
	int n_flagged;

	pci_host_bridge_config_space dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.port_offset    (port_offset),
		.access_len     (access_len),
		.wdata          (wdata),
		.mem_addr       (mem_addr),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.rdata          (rdata),
		.error          (error),
		.seg_read_dram  (seg_read_dram),
		.seg_write_dram (seg_write_dram)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Computes the response of the bridge to one request and applies any side effect
	// to the shadow state. Address port and data port follow configuration mechanism #1;
	// a segment query looks up the attribute nibble of the 16 KiB segment.
	function automatic bridge_rsp_t bridge_response(input bridge_req_t r);
		bridge_rsp_t o;
		logic [7:0]  base;
		logic [7:0]  off;
		logic [7:0]  b;
		logic [7:0]  seg;
		logic [7:0]  pam;
		logic [3:0]  k;
		logic        hi;
		logic        writable;
		o = '0;
		case (r.kind)
			REQ_PORT_READ, REQ_PORT_WRITE: begin
				if (r.kind == REQ_PORT_READ)
					o.rdata = ALL_ONES;
				if (r.port == PORT_ADDRESS) begin
					if (r.len != LEN_DWORD)
						o.err = 1'b1;
					else if (r.kind == REQ_PORT_READ)
						o.rdata = cfg_addr_model;
					else
						cfg_addr_model = r.wdata;
				end else if (r.port < PORT_DATA0) begin
					o.err = 1'b1;
				end else if (r.len >= 3'd1 && r.len <= LEN_DWORD
						&& (cfg_addr_model & CA_MATCH_MASK) == CA_MATCH_VALUE
						&& cfg_addr_model[15:8] == 8'h00) begin
					// The dword-aligned register plus the byte lane of the data port.
					base = {cfg_addr_model[7:2], r.port[1:0]};
					if (r.kind == REQ_PORT_READ) begin
						o.rdata = '0;
						for (k = 4'd0; k < {1'b0, r.len}; k++) begin
							off = base + {4'd0, k};
							o.rdata[8*k +: 8] = cfg_space_model[off];
						end
					end else begin
						// The filter looks only at the first register of the access.
						writable = (base >= OFF_COMMAND && base <= CMD_STATUS_LAST)
							|| base == OFF_CACHE_LS || base == LATENCY_TIMER
							|| base > HEADER_TYPE;
						if (base >= OFF_BAR_FIRST && base < OFF_BAR_END)
							writable = 1'b0;
						for (k = 4'd0; writable && k < {1'b0, r.len}; k++) begin
							off = base + {4'd0, k};
							b = r.wdata[8*k +: 8];
							if (off == OFF_COMMAND)
								cfg_space_model[off] = (b & CMD_KEEP_MASK) | CMD_FORCED;
							else if (off != OFF_STATUS_LO && off != OFF_CACHE_LS)
								cfg_space_model[off] = b;
						end
					end
				end
			end
			REQ_SEG_QUERY: begin
				seg = {r.mem_addr[19:14], 2'b00};
				if (seg < SEG_FIRST_LEGACY) begin
					o.err = 1'b1;
				end else begin
					if (seg >= SEG_UPPER_BIOS) begin
						pam = cfg_space_model[OFF_PAM0];
						hi = 1'b1;
					end else begin
						pam = cfg_space_model[OFF_PAM1 + ((seg - SEG_FIRST_LEGACY) >> 3)];
						hi = seg[2];
					end
					o.rd_dram = hi ? pam[4] : pam[0];
					o.wr_dram = hi ? pam[5] : pam[1];
				end
			end
			default: begin
				o.rdata = ALL_ONES;
				o.err = 1'b1;
			end
		endcase
		return o;
	endfunction

	function automatic void add_vector(input bit fixed, input logic [1:0] kind,
			input logic [2:0] port, input logic [2:0] len, input logic [31:0] wd,
			input logic [19:0] ma, input logic [31:0] x_rdata, input logic x_err);
		script_row_t row;
		row.req = '{kind: kind, port: port, len: len, wdata: wd, mem_addr: ma};
		row.fixed = fixed;
		row.rsp = '{rdata: x_rdata, err: x_err, rd_dram: 1'b0, wr_dram: 1'b0};
		directed_rows.push_back(row);
	endfunction

	// Presents one request, optionally after a few idle cycles, and holds it until the
	// bridge takes the transfer. The expected response is queued at that very edge.
	task automatic offer_item(input bridge_req_t r, input bit fixed, input bridge_rsp_t want);
		bridge_rsp_t model_rsp;
		int gap;
		gap = 0;
		if (!calm && $urandom_range(99) < 20)
			gap = $urandom_range(6, 1);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= r.kind;
		port_offset <= r.port;
		access_len <= r.len;
		wdata <= r.wdata;
		mem_addr <= r.mem_addr;
		do
			@(posedge clk);
		while (!in_ready);
		model_rsp = bridge_response(r);
		awaited_responses.push_back(fixed ? want : model_rsp);
		items_sent++;
		case (r.kind)
			REQ_PORT_READ:  n_port_reads++;
			REQ_PORT_WRITE: n_port_writes++;
			REQ_SEG_QUERY:  n_seg_queries++;
			default:        n_undefined++;
		endcase
	endtask

	// Receiver. It stalls at random, except during the calm stretch, and once holds off
	// for a long time so that the bridge backs up and refuses new requests.
	initial begin : sink
		out_ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 11);
				@(posedge clk);
			end
		end
	end

	// Every result transfer is compared with the oldest expected response. The same block
	// counts cycles in which neither side moves a transfer, for the watchdog.
	always @(posedge clk) begin : result_check
		bridge_rsp_t got;
		bridge_rsp_t want;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (out_valid && out_ready) begin
				got = '{rdata: rdata, err: error, rd_dram: seg_read_dram,
					wr_dram: seg_write_dram};
				if (got.err)
					n_flagged++;
				if (awaited_responses.size() == 0) begin
					if (bad_results < 10)
						$display("%t: result with nothing outstanding: rdata %h error %b rd %b wr %b",
							$realtime, got.rdata, got.err, got.rd_dram, got.wr_dram);
					bad_results++;
				end else begin
					want = awaited_responses.pop_front();
					if (got.rdata !== want.rdata || got.err !== want.err
							|| got.rd_dram !== want.rd_dram || got.wr_dram !== want.wr_dram) begin
						if (bad_results < 10)
							$display("%t: result %0d differs: expected rdata %h error %b rd %b wr %b, got rdata %h error %b rd %b wr %b",
								$realtime, results_checked, want.rdata, want.err, want.rd_dram,
								want.wr_dram, got.rdata, got.err, got.rd_dram, got.wr_dram);
						bad_results++;
					end
					results_checked++;
				end
			end
		end
	end

	// The watchdog ends a run in which nothing has moved for far longer than the long
	// receiver hold-off plus the slowest request could explain.
	initial begin : watchdog
		wait (arst_n);
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("watchdog: no transfer in %0d cycles, %0d responses outstanding",
			QUIET_LIMIT, awaited_responses.size());
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : stimulus
		bridge_req_t r;
		logic [31:0] rnd;
		logic [31:0] sel;
		int          pick;
		int          burst;
		bit          squeeze_done;
		int          i;

		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_PORT_READ;
		port_offset = PORT_ADDRESS;
		access_len = LEN_DWORD;
		wdata = '0;
		mem_addr = '0;
		calm = 1'b0;
		sink_hold_req = 1'b0;
		squeeze_done = 1'b0;

		// Power-on image of the configuration space: identity, command, status,
		// class code, and the DRAM and attribute defaults.
		cfg_addr_model = '0;
		for (i = 0; i < 256; i++)
			cfg_space_model[i] = 8'h00;
		cfg_space_model[8'h00] = 8'h86;
		cfg_space_model[8'h01] = 8'h80;
		cfg_space_model[8'h02] = 8'h37;
		cfg_space_model[8'h03] = 8'h12;
		cfg_space_model[8'h04] = 8'h06;
		cfg_space_model[8'h06] = 8'h80;
		cfg_space_model[8'h07] = 8'h02;
		cfg_space_model[8'h0B] = 8'h06;
		cfg_space_model[8'h51] = 8'h01;
		cfg_space_model[8'h53] = 8'h80;
		cfg_space_model[8'h57] = 8'h01;
		cfg_space_model[8'h58] = 8'h10;

		// Directed script. Columns: fixed, request, port, length, write data,
		// memory address, then the hand-worked read data and error flag.
		// Right after reset the address register is zero, so the data port is closed.
		add_vector(1, REQ_PORT_READ,  PORT_ADDRESS, 3'd4, 32'h0000_0000, 20'h00000,
			32'h0000_0000, 1'b0);
		add_vector(1, REQ_PORT_READ,  PORT_ADDRESS, 3'd2, 32'h0000_0000, 20'h00000,
			ALL_ONES, 1'b1);
		add_vector(1, REQ_PORT_WRITE, PORT_ADDRESS, 3'd3, 32'h8000_0000, 20'h00000,
			32'h0000_0000, 1'b1);
		add_vector(1, REQ_PORT_READ,  PORT_DATA0,   3'd4, 32'h0000_0000, 20'h00000,
			ALL_ONES, 1'b0);
		add_vector(1, REQ_PORT_READ,  PORT_GAP_LO,  3'd4, 32'h0000_0000, 20'h00000,
			ALL_ONES, 1'b1);
		add_vector(1, REQ_PORT_WRITE, PORT_GAP_HI,  3'd1, 32'hFFFF_FFFF, 20'hFFFFF,
			32'h0000_0000, 1'b1);
		add_vector(1, REQ_UNDEFINED,  PORT_ADDRESS, 3'd4, 32'hFFFF_FFFF, 20'hFFFFF,
			ALL_ONES, 1'b1);
		add_vector(1, REQ_SEG_QUERY,  PORT_ADDRESS, 3'd0, 32'h0000_0000, 20'h00000,
			32'h0000_0000, 1'b1);
		add_vector(1, REQ_SEG_QUERY,  PORT_ADDRESS, 3'd0, 32'h0000_0000, 20'hBFFFF,
			32'h0000_0000, 1'b1);
		// Open the bridge at register 0 and read its identity.
		add_vector(1, REQ_PORT_WRITE, PORT_ADDRESS, 3'd4, 32'h8000_0000, 20'h00000,
			32'h0000_0000, 1'b0);
		add_vector(1, REQ_PORT_READ,  PORT_DATA0,   3'd4, 32'h0000_0000, 20'h00000,
			32'h1237_8086, 1'b0);
		// Zero and oversized lengths on an open data port read all ones without error.
		add_vector(1, REQ_PORT_READ,  PORT_DATA0,   3'd0, 32'h0000_0000, 20'h00000,
			ALL_ONES, 1'b0);
		add_vector(1, REQ_PORT_READ,  PORT_DATA0 + 3'd1, 3'd7, 32'h0000_0000, 20'h00000,
			ALL_ONES, 1'b0);
		// A dword at the last register wraps around to the identity bytes.
		add_vector(1, REQ_PORT_WRITE, PORT_ADDRESS, 3'd4, 32'h8000_00FC, 20'h00000,
			32'h0000_0000, 1'b0);
		add_vector(0, REQ_PORT_WRITE, PORT_DATA0 + 3'd3, 3'd4, 32'hA1B2_C3D4, 20'h00000,
			32'h0, 1'b0);
		add_vector(0, REQ_PORT_READ,  PORT_DATA0 + 3'd3, 3'd4, 32'h0000_0000, 20'h00000,
			32'h0, 1'b0);
		// Command byte keeps only one bit, the low status byte is read only.
		add_vector(1, REQ_PORT_WRITE, PORT_ADDRESS, 3'd4, 32'h8000_0004, 20'h00000,
			32'h0000_0000, 1'b0);
		add_vector(0, REQ_PORT_WRITE, PORT_DATA0,   3'd4, 32'hFFFF_FFFF, 20'h00000,
			32'h0, 1'b0);
		add_vector(0, REQ_PORT_READ,  PORT_DATA0,   3'd4, 32'h0000_0000, 20'h00000,
			32'h0, 1'b0);
		// The cache line size byte ignores writes while the latency timer takes them.
		add_vector(1, REQ_PORT_WRITE, PORT_ADDRESS, 3'd4, 32'h8000_000C, 20'h00000,
			32'h0000_0000, 1'b0);
		add_vector(0, REQ_PORT_WRITE, PORT_DATA0,   3'd2, 32'h0000_BBAA, 20'h00000,
			32'h0, 1'b0);
		// The base address registers drop the whole write.
		add_vector(1, REQ_PORT_WRITE, PORT_ADDRESS, 3'd4, 32'h8000_0010, 20'h00000,
			32'h0000_0000, 1'b0);
		add_vector(0, REQ_PORT_WRITE, PORT_DATA0,   3'd4, 32'hFFFF_FFFF, 20'h00000,
			32'h0, 1'b0);
		// Program the attribute bytes and query the segments they govern.
		add_vector(1, REQ_PORT_WRITE, PORT_ADDRESS, 3'd4, 32'h8000_0058, 20'h00000,
			32'h0000_0000, 1'b0);
		add_vector(0, REQ_PORT_WRITE, PORT_DATA0 + 3'd1, 3'd4, 32'h5500_2130, 20'h00000,
			32'h0, 1'b0);
		add_vector(0, REQ_SEG_QUERY,  PORT_ADDRESS, 3'd0, 32'h0000_0000, 20'hFFFFF,
			32'h0, 1'b0);
		add_vector(0, REQ_SEG_QUERY,  PORT_ADDRESS, 3'd0, 32'h0000_0000, 20'hC0000,
			32'h0, 1'b0);
		add_vector(0, REQ_SEG_QUERY,  PORT_ADDRESS, 3'd0, 32'h0000_0000, 20'hC4000,
			32'h0, 1'b0);
		// A nonzero bus number makes the data port answer with all ones and no error.
		add_vector(1, REQ_PORT_WRITE, PORT_ADDRESS, 3'd4, 32'h8001_0000, 20'h00000,
			32'h0000_0000, 1'b0);
		add_vector(1, REQ_PORT_READ,  PORT_DATA0,   3'd4, 32'h0000_0000, 20'h00000,
			ALL_ONES, 1'b0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			offer_item(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].rsp);

		// Random traffic. Most of it is a configuration transaction: an address port write
		// that usually opens the bridge, followed by a short burst of data port accesses.
		// Queries lean toward the legacy segments, and a share of the requests is noise.
		while (items_sent < TARGET_ITEMS) begin
			calm = (items_sent >= CALM_FIRST && items_sent < CALM_LAST);
			if (items_sent >= SQUEEZE_AT && !squeeze_done) begin
				squeeze_done = 1'b1;
				sink_hold_req = 1'b1;
			end
			rnd = $urandom;
			r.wdata = $urandom;
			r.mem_addr = rnd[19:0];
			pick = $urandom_range(99);
			if (pick < 55) begin
				sel = $urandom;
				r.kind = REQ_PORT_WRITE;
				r.port = PORT_ADDRESS;
				r.len = LEN_DWORD;
				if (sel[3:0] != 4'd0)
					r.wdata[31] = 1'b1;
				if (sel[7:4] != 4'd0)
					r.wdata[23:16] = 8'h00;
				if (sel[11:8] > 4'd1)
					r.wdata[15:8] = 8'h00;
				// Steer some transactions onto the attribute bytes and some onto the header.
				if (sel[13:12] == 2'd0)
					r.wdata[7:0] = {4'h5, 1'b1, sel[14], sel[16:15]};
				else if (sel[13:12] == 2'd1)
					r.wdata[7:6] = 2'b00;
				offer_item(r, 1'b0, '0);
				burst = $urandom_range(4, 1);
				repeat (burst) begin
					rnd = $urandom;
					r.kind = rnd[0] ? REQ_PORT_WRITE : REQ_PORT_READ;
					r.port = {1'b1, rnd[2:1]};
					r.len = {1'b0, rnd[4:3]} + 3'd1;
					r.wdata = $urandom;
					r.mem_addr = rnd[31:12];
					offer_item(r, 1'b0, '0);
				end
			end else if (pick < 75) begin
				r.kind = REQ_SEG_QUERY;
				r.port = rnd[22:20];
				r.len = rnd[25:23];
				if (pick < 71)
					r.mem_addr[19:18] = 2'b11;
				offer_item(r, 1'b0, '0);
			end else if (pick < 85) begin
				r.kind = REQ_PORT_READ;
				r.port = PORT_ADDRESS;
				r.len = LEN_DWORD;
				offer_item(r, 1'b0, '0);
			end else begin
				r.kind = rnd[21:20];
				r.port = rnd[24:22];
				r.len = rnd[27:25];
				offer_item(r, 1'b0, '0);
			end
		end

		calm = 1'b0;
		in_valid <= 1'b0;
		while (awaited_responses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d transfers checked: %0d port reads, %0d port writes, %0d segment queries, %0d undefined requests",
			results_checked, n_port_reads, n_port_writes, n_seg_queries, n_undefined);
		$display("%0d responses flagged an error, %0d responses differed from the prediction",
			n_flagged, bad_results);
		if (bad_results == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
